// ----- hdl/text_console_writer_defines.svh -----
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text console writer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text console writer: next-cycle check failed");

`endif

// ----- hdl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, character codes and the command passed from front to back.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int CELL_W   = 16;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 8;
    localparam int POS_W    = 11;
    localparam int ROW_IN_W = 5;
    localparam int COL_IN_W = 7;
    // Wide enough for the largest screen, 64 rows of 256 columns.
    localparam int ADDR_W   = 14;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;
    localparam logic [CELL_W-1:0]  RESET_CELL   = 16'h0720;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;      // logical linear cell index
        logic [CELL_W-1:0] cell_word; // color in the high byte
        logic              scroll;
        logic [POS_W-1:0]  position;
    } cmd_t;

endpackage

// ----- hdl/tcw_if.sv -----
// ----------------------------------------------------------------------------
// Text console writer channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface tcw_req_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [tcw_pkg::CHAR_W-1:0]    char_code;
    logic [tcw_pkg::ROW_IN_W-1:0]  read_row;
    logic [tcw_pkg::COL_IN_W-1:0]  read_column;

    modport source (output valid, opcode, char_code, read_row, read_column, input ready);
    modport sink   (input valid, opcode, char_code, read_row, read_column, output ready);
endinterface

interface tcw_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::CELL_W-1:0]  cell_value;
    logic [tcw_pkg::POS_W-1:0]   cursor_position;
    logic                        scrolled;

    modport source (output valid, cell_value, cursor_position, scrolled, input ready);
    modport sink   (input valid, cell_value, cursor_position, scrolled, output ready);
endinterface

// ----- hdl/tcw_front.sv -----
// ----------------------------------------------------------------------------
// Text console writer front end
// Accepts items, tracks the cursor and turns each item into a store command.
// ----------------------------------------------------------------------------
module tcw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [tcw_pkg::COLOR_W-1:0]  color,
    input  logic                         init_done,
    input  logic                         q_full,
    tcw_req_if.sink                      req,
    output logic                         push,
    output tcw_pkg::cmd_t                cmd
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int RW    = $clog2(ROWS + 1);
    localparam int CW    = $clog2(COLUMNS);
    localparam int PW    = $clog2(CELLS + 1);

    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [PW-1:0] pos_reg, pos_next;

    logic                      in_range;
    logic [tcw_pkg::ADDR_W-1:0] rd_addr;

    assign req.ready = init_done && !q_full;
    assign push      = req.valid && req.ready;

    assign in_range = (7'(req.read_row) < 7'(ROWS)) && (9'(req.read_column) < 9'(COLUMNS));
    assign rd_addr  = tcw_pkg::ADDR_W'(tcw_pkg::ADDR_W'(req.read_row) *
                                       tcw_pkg::ADDR_W'(COLUMNS))
                    + tcw_pkg::ADDR_W'(req.read_column);

    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        pos_next       = pos_reg;
        cmd.kind       = tcw_pkg::KIND_NONE;
        cmd.addr       = rd_addr;
        cmd.cell_word  = {color, req.char_code};
        cmd.scroll     = 1'b0;
        cmd.position   = tcw_pkg::POS_W'(pos_reg);
        if (req.opcode == tcw_pkg::OP_READ)
        begin
            cmd.kind = in_range ? tcw_pkg::KIND_READ : tcw_pkg::KIND_NONE;
        end
        else
        begin
            if (req.char_code == tcw_pkg::NEWLINE_CODE)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
                pos_next = pos_reg - PW'(col_reg) + PW'(COLUMNS);
            end
            else
            begin
                cmd.kind = tcw_pkg::KIND_WRITE;
                cmd.addr = tcw_pkg::ADDR_W'(pos_reg);
                pos_next = pos_reg + 1'b1;
                if (col_reg == CW'(COLUMNS - 1))
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            // Running off the bottom pins the cursor to the start of the last row.
            if (row_next == RW'(ROWS))
            begin
                cmd.scroll = 1'b1;
                row_next   = RW'(ROWS - 1);
                pos_next   = pos_next - PW'(COLUMNS);
            end
            cmd.position = tcw_pkg::POS_W'(pos_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            pos_reg <= '0;
        end
        else if (push)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            pos_reg <= pos_next;
        end
    end

endmodule

// ----- hdl/tcw_queue.sv -----
// ----------------------------------------------------------------------------
// Text console writer command queue
// Two-entry queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module tcw_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tcw_pkg::cmd_t push_data,
    input  logic          pop,
    output tcw_pkg::cmd_t pop_data,
    output logic          full,
    output logic          empty
);

    tcw_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- hdl/tcw_back.sv -----
// ----------------------------------------------------------------------------
// Text console writer back end
// Owns the cell store as a ring of rows, executes commands and sends results.
// ----------------------------------------------------------------------------
module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  tcw_pkg::cmd_t head,
    output logic          pop,
    output logic          init_done,
    tcw_rsp_if.source     rsp
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_BLANK = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic [AW-1:0]                  sweep_reg, sweep_next;
    logic [CW-1:0]                  blank_cnt_reg, blank_cnt_next;
    logic [AW-1:0]                  top_base_reg, top_base_next;
    logic [tcw_pkg::CELL_W-1:0]     blank_cell_reg, blank_cell_next;
    logic [tcw_pkg::POS_W-1:0]      rd_pos_reg, rd_pos_next;

    logic                           out_valid_reg, out_valid_next;
    logic [tcw_pkg::CELL_W-1:0]     out_cell_reg, out_cell_next;
    logic [tcw_pkg::POS_W-1:0]      out_pos_reg, out_pos_next;
    logic                           out_scroll_reg, out_scroll_next;

    logic [tcw_pkg::CELL_W-1:0]     text_store_reg [CELLS];
    logic [tcw_pkg::CELL_W-1:0]     rdata_reg;

    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]     mem_wdata;
    logic                           mem_re;

    logic                           out_free;
    logic [AW:0]                    phys_sum;
    logic [AW-1:0]                  phys_addr;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign pop       = (state_reg == S_RUN) && !q_empty && out_free;
    assign init_done = (state_reg != S_CLEAR);

    // Logical cell index offset by the row that currently sits at the top.
    assign phys_sum  = {1'b0, AW'(head.addr)} + {1'b0, top_base_reg};
    assign phys_addr = (phys_sum >= (AW + 1)'(CELLS)) ? AW'(phys_sum - (AW + 1)'(CELLS))
                                                       : AW'(phys_sum);

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        blank_cnt_next  = blank_cnt_reg;
        top_base_next   = top_base_reg;
        blank_cell_next = blank_cell_reg;
        rd_pos_next     = rd_pos_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_cell_next   = out_cell_reg;
        out_pos_next    = out_pos_reg;
        out_scroll_next = out_scroll_reg;
        mem_we          = 1'b0;
        mem_waddr       = sweep_reg;
        mem_wdata       = tcw_pkg::RESET_CELL;
        mem_re          = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == AW'(CELLS - 1))
                begin
                    sweep_next = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (pop)
                begin
                    if (head.kind == tcw_pkg::KIND_READ)
                    begin
                        mem_re      = 1'b1;
                        rd_pos_next = head.position;
                        state_next  = S_READ;
                    end
                    else
                    begin
                        if (head.kind == tcw_pkg::KIND_WRITE)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = phys_addr;
                            mem_wdata = head.cell_word;
                        end
                        out_valid_next  = 1'b1;
                        out_cell_next   = '0;
                        out_pos_next    = head.position;
                        out_scroll_next = head.scroll;
                    end
                    if (head.scroll)
                    begin
                        // The old top row becomes the new bottom row and is blanked.
                        sweep_next      = top_base_reg;
                        blank_cnt_next  = '0;
                        blank_cell_next = {head.cell_word[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W],
                                           tcw_pkg::BLANK_CODE};
                        top_base_next   = (top_base_reg == AW'(CELLS - COLUMNS))
                                        ? '0 : top_base_reg + AW'(COLUMNS);
                        state_next      = S_BLANK;
                    end
                end
            end
            S_READ:
            begin
                out_valid_next  = 1'b1;
                out_cell_next   = rdata_reg;
                out_pos_next    = rd_pos_reg;
                out_scroll_next = 1'b0;
                state_next      = S_RUN;
            end
            S_BLANK:
            begin
                mem_we         = 1'b1;
                mem_wdata      = blank_cell_reg;
                sweep_next     = sweep_reg + 1'b1;
                blank_cnt_next = blank_cnt_reg + 1'b1;
                if (blank_cnt_reg == CW'(COLUMNS - 1))
                begin
                    sweep_next = '0;
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            text_store_reg[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= text_store_reg[phys_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        blank_cell_reg <= blank_cell_next;
        rd_pos_reg     <= rd_pos_next;
        out_cell_reg   <= out_cell_next;
        out_pos_reg    <= out_pos_next;
        out_scroll_reg <= out_scroll_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sweep_reg     <= '0;
            blank_cnt_reg <= '0;
            top_base_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            blank_cnt_reg <= blank_cnt_next;
            top_base_reg  <= top_base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.cell_value      = out_cell_reg;
    assign rsp.cursor_position = out_pos_reg;
    assign rsp.scrolled        = out_scroll_reg;

endmodule

// ----- hdl/text_console_writer.sv -----
// Path: a put beat is answered through the queue entry and the output register,
// a read beat through the store read register as well. Throughput: one put per cycle
// while the response side is ready; the back end takes no command in S_READ or S_BLANK.
// Reset: rst_n clears the cursor, the color (to 7) and all control state at once,
// then a clearing pass writes every cell of the store before any beat is taken.
// ----------------------------------------------------------------------------
// Text console writer
// Text cell store with a cursor, put-character and read-cell requests.
// ----------------------------------------------------------------------------
`include "text_console_writer_defines.svh"

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [tcw_pkg::COLOR_W-1:0]  cfg_data,
    tcw_req_if.sink                      req,
    tcw_rsp_if.source                    rsp
);

    // The front end owns the cursor. It decides for each beat whether a cell is
    // written, read or left alone, and whether the screen scrolls. The back end
    // owns the store, kept as a ring of rows so that a scroll only moves the top
    // row pointer and blanks one row. The queue between them lets the front keep
    // taking beats while the back blanks a row or waits on the response side.

    logic [tcw_pkg::COLOR_W-1:0] color_reg;

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    logic          init_done;
    tcw_pkg::cmd_t push_cmd;
    tcw_pkg::cmd_t head_cmd;

    // The color is captured into every command, so a later write to it does not
    // touch a row that is still being blanked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= tcw_pkg::RESET_COLOR;
        end
        else if (cfg_write)
        begin
            color_reg <= cfg_data;
        end
    end

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .color     (color_reg),
        .init_done (init_done),
        .q_full    (q_full),
        .req       (req),
        .push      (push),
        .cmd       (push_cmd)
    );

    tcw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (head_cmd),
        .full      (q_full),
        .empty     (q_empty)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head_cmd),
        .pop       (pop),
        .init_done (init_done),
        .rsp       (rsp)
    );

    // No beat is taken while the store is still being cleared after reset.
    `TCW_ASSERT_NOW(a_no_accept_in_clear, req.valid && req.ready, init_done)

    // The queue never takes a command when it is full.
    `TCW_ASSERT_NOW(a_no_push_when_full, push, !q_full)

    // A scrolled put leaves the cursor at the start of the last row.
    `TCW_ASSERT_NOW(a_scroll_position, rsp.valid && rsp.scrolled,
                    rsp.cursor_position == tcw_pkg::POS_W'((ROWS - 1) * COLUMNS))

    // Taking a command from a full queue frees an entry by the next cycle.
    `TCW_ASSERT_NEXT(a_pop_leaves_count, pop && !push && q_full, !q_full)

endmodule

// ----- tb/tb_text_console_writer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Sends put-character and read-cell beats under random valid/ready idling and
// checks every response against a cycle-free model of the screen and cursor.
// ----------------------------------------------------------------------------
module tb_text_console_writer;

    import tcw_pkg::*;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

    // The clearing pass after reset fills every cell without a beat, so the
    // watchdog limit sits well above its length.
    localparam int unsigned QUIET_LIMIT  = 20000;
    // A scroll blanks the bottom row one cell per cycle; wait that out and
    // a little more before touching the color register.
    localparam int unsigned SETTLE_CYCLES = SCREEN_COLUMNS + 20;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned TAIL_CYCLES   = 10;

    // One request beat as it appears on the request channel.
    typedef struct packed {
        logic                opcode;
        logic [CHAR_W-1:0]   char_code;
        logic [ROW_IN_W-1:0] read_row;
        logic [COL_IN_W-1:0] read_column;
    } console_item_t;

    // One response beat as it appears on the response channel.
    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [POS_W-1:0]  cursor_position;
        logic              scrolled;
    } console_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [COLOR_W-1:0]   cfg_data;

    tcw_req_if req_ch ();
    tcw_rsp_if rsp_ch ();

    text_console_writer #(
        .COLUMNS (SCREEN_COLUMNS),
        .ROWS    (SCREEN_ROWS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Beats waiting to be offered, and responses that accepted beats owe us.
    console_item_t   beats_to_send [$];
    console_result_t responses_due [$];

    // Model of the screen: cell store, cursor and the current attribute.
    logic [CELL_W-1:0]   screen_cells [0:CELL_COUNT-1];
    logic [ROW_IN_W-1:0] cursor_row_m;
    logic [COL_IN_W-1:0] cursor_column_m;
    logic [COLOR_W-1:0]  text_color_m;

    // Percentages of cycles in which the sender or the receiver stays idle.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // Long receiver hold-off, requested by the sequence and timed by the
    // response process itself.
    logic        hold_request;
    logic        hold_done;
    int unsigned hold_count;

    int unsigned beats_queued;
    int unsigned beats_accepted;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;

    // ------------------------------------------------------------------------
    // Screen model. Works out the response for one accepted beat and updates
    // the store and the cursor the way the block should.
    // ------------------------------------------------------------------------
    function automatic console_result_t predict_console_result(console_item_t item);
        console_result_t res;
        res = '0;
        if (item.opcode == OP_READ)
        begin
            // A read outside the screen returns zero; no read changes anything.
            if (int'(item.read_row) < SCREEN_ROWS && int'(item.read_column) < SCREEN_COLUMNS)
                res.cell_value = screen_cells[int'(item.read_row) * SCREEN_COLUMNS
                                              + int'(item.read_column)];
        end
        else
        begin
            if (item.char_code == NEWLINE_CODE)
            begin
                cursor_column_m = '0;
                cursor_row_m    = cursor_row_m + 1'b1;
            end
            else
            begin
                // Every byte other than newline is stored, zero and control
                // bytes included.
                screen_cells[int'(cursor_row_m) * SCREEN_COLUMNS + int'(cursor_column_m)] =
                    {text_color_m, item.char_code};
                cursor_column_m = cursor_column_m + 1'b1;
                if (int'(cursor_column_m) >= SCREEN_COLUMNS)
                begin
                    cursor_column_m = '0;
                    cursor_row_m    = cursor_row_m + 1'b1;
                end
            end
            // Running off the bottom scrolls everything up one row and fills
            // the new bottom row with blanks in the current attribute.
            if (int'(cursor_row_m) >= SCREEN_ROWS)
            begin
                for (int i = 0; i < CELL_COUNT - SCREEN_COLUMNS; i++)
                    screen_cells[i] = screen_cells[i + SCREEN_COLUMNS];
                for (int i = CELL_COUNT - SCREEN_COLUMNS; i < CELL_COUNT; i++)
                    screen_cells[i] = {text_color_m, BLANK_CODE};
                cursor_row_m = ROW_IN_W'(SCREEN_ROWS - 1);
                res.scrolled = 1'b1;
            end
        end
        res.cursor_position = POS_W'(int'(cursor_row_m) * SCREEN_COLUMNS
                                     + int'(cursor_column_m));
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Request driver. A beat stays on the channel until it is taken; only then
    // may the next one (or a gap) follow. The model is advanced at the edge at
    // which the beat is accepted, so its response is due in beat order.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        console_item_t next_beat;
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.opcode      <= OP_PUT;
            req_ch.char_code   <= '0;
            req_ch.read_row    <= '0;
            req_ch.read_column <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                responses_due.push_back(predict_console_result(
                    {req_ch.opcode, req_ch.char_code, req_ch.read_row, req_ch.read_column}));
                beats_accepted++;
            end
            if (req_ch.valid && !req_ch.ready)
            begin
                // Beat still waiting; keep it steady.
            end
            else if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_beat = beats_to_send.pop_front();
                req_ch.valid       <= 1'b1;
                req_ch.opcode      <= next_beat.opcode;
                req_ch.char_code   <= next_beat.char_code;
                req_ch.read_row    <= next_beat.read_row;
                req_ch.read_column <= next_beat.read_column;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor. Every beat taken on the response channel is checked
    // against the oldest response due. Ready is thrown at random, except
    // during the requested hold-off, when it stays low until the hold-off is done.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : response_monitor
        console_result_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_count   <= 0;
            hold_done    <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready)
            begin
                if (responses_due.size() == 0)
                begin
                    $error("response beat with no request outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = responses_due.pop_front();
                    if (rsp_ch.cell_value !== want.cell_value)
                    begin
                        $error("cell_value: expected %h, got %h",
                               want.cell_value, rsp_ch.cell_value);
                        mismatch_count++;
                    end
                    if (rsp_ch.cursor_position !== want.cursor_position)
                    begin
                        $error("cursor_position: expected %0d, got %0d",
                               want.cursor_position, rsp_ch.cursor_position);
                        mismatch_count++;
                    end
                    if (rsp_ch.scrolled !== want.scrolled)
                    begin
                        $error("scrolled: expected %b, got %b",
                               want.scrolled, rsp_ch.scrolled);
                        mismatch_count++;
                    end
                end
            end
            if (hold_request && !hold_done)
            begin
                rsp_ch.ready <= 1'b0;
                hold_count   <= hold_count + 1;
                if (hold_count == HOLD_CYCLES - 1)
                    hold_done <= 1'b1;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a long run of cycles with no beat on either channel means the
    // block has hung.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence helpers.
    // ------------------------------------------------------------------------
    task automatic queue_beat(input logic opcode, input logic [CHAR_W-1:0] char_code,
                              input int unsigned row, input int unsigned column);
        beats_to_send.push_back({opcode, char_code, ROW_IN_W'(row), COL_IN_W'(column)});
        beats_queued++;
    endtask

    // Random beats. Reads mostly land on the screen, some anywhere the field
    // widths allow. Puts carry any byte, with newlines weighted up so the
    // cursor keeps reaching the bottom and scrolling.
    task automatic queue_random_beats(input int unsigned count, input int unsigned newline_pct,
                                      input int unsigned read_pct);
        logic                opcode;
        logic [CHAR_W-1:0]   char_code;
        int unsigned         row;
        int unsigned         column;
        repeat (count)
        begin
            opcode    = ($urandom_range(99) < read_pct) ? OP_READ : OP_PUT;
            char_code = ($urandom_range(99) < newline_pct) ? NEWLINE_CODE
                                                           : CHAR_W'($urandom_range(255));
            if ($urandom_range(9) < 2)
            begin
                row    = $urandom_range((1 << ROW_IN_W) - 1);
                column = $urandom_range((1 << COL_IN_W) - 1);
            end
            else
            begin
                row    = $urandom_range(SCREEN_ROWS - 1);
                column = $urandom_range(SCREEN_COLUMNS - 1);
            end
            queue_beat(opcode, char_code, row, column);
        end
    endtask

    // Waits until every queued beat has been taken and answered, then lets
    // any trailing row blanking finish so the block is truly idle.
    task automatic wait_until_idle();
        while (beats_accepted != beats_queued || responses_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_text_color(input logic [COLOR_W-1:0] color);
        @(posedge clk);
        cfg_write    <= 1'b1;
        cfg_data     <= color;
        text_color_m  = color;
        @(posedge clk);
        cfg_write    <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        // Every input known from time zero, while reset is held low.
        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_PUT;
        req_ch.char_code   = '0;
        req_ch.read_row    = '0;
        req_ch.read_column = '0;
        rsp_ch.ready       = 1'b0;
        hold_request       = 1'b0;
        send_idle_pct      = 31;
        recv_idle_pct      = 75;
        beats_queued       = 0;
        beats_accepted     = 0;
        mismatch_count     = 0;
        quiet_cycles       = 0;
        for (int i = 0; i < CELL_COUNT; i++)
            screen_cells[i] = RESET_CELL;
        cursor_row_m    = '0;
        cursor_column_m = '0;
        text_color_m    = RESET_COLOR;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats with the reset attribute. Corners of the screen and
        // reads just past it, the all-ones read fields, character zero, 0xFF
        // and a few control bytes, newline, and read-back of what was put.
        queue_beat(OP_READ, 8'h00, 0, 0);
        queue_beat(OP_READ, 8'hFF, SCREEN_ROWS - 1, SCREEN_COLUMNS - 1);
        queue_beat(OP_READ, 8'h00, SCREEN_ROWS, 0);
        queue_beat(OP_READ, 8'h00, 0, SCREEN_COLUMNS);
        queue_beat(OP_READ, 8'h00, (1 << ROW_IN_W) - 1, (1 << COL_IN_W) - 1);
        queue_beat(OP_PUT, 8'h00, 0, 0);
        queue_beat(OP_PUT, 8'hFF, (1 << ROW_IN_W) - 1, (1 << COL_IN_W) - 1);
        queue_beat(OP_PUT, 8'h0D, 0, 0);
        queue_beat(OP_PUT, 8'h09, 0, 0);
        queue_beat(OP_PUT, 8'h7F, 0, 0);
        queue_beat(OP_PUT, 8'h80, 0, 0);
        queue_beat(OP_READ, 8'h00, 0, 0);
        queue_beat(OP_READ, 8'h00, 0, 1);
        queue_beat(OP_READ, 8'h00, 0, 5);
        queue_beat(OP_READ, 8'h00, 0, 6);
        queue_beat(OP_PUT, NEWLINE_CODE, 0, 0);
        queue_beat(OP_PUT, NEWLINE_CODE, 0, 0);
        queue_beat(OP_PUT, 8'h41, 0, 0);
        queue_beat(OP_PUT, 8'h0B, 0, 0);
        queue_beat(OP_READ, 8'h00, 2, 0);
        queue_beat(OP_READ, 8'h00, 2, 1);
        queue_beat(OP_READ, 8'h00, 1, 0);
        wait_until_idle();

        // Black on black, sender idling lightly, receiver heavily.
        write_text_color(8'h00);
        queue_random_beats(320, 8, 35);
        wait_until_idle();

        // All attribute bits set; the idling swaps sides and newlines come
        // often, so the screen scrolls again and again.
        write_text_color(8'hFF);
        send_idle_pct = 75;
        recv_idle_pct = 31;
        queue_random_beats(320, 25, 35);
        wait_until_idle();

        // A random attribute at full rate on both sides. The receiver holds
        // off for a long stretch at the start while beats keep coming, so the
        // block backs up and stops taking requests.
        write_text_color(COLOR_W'($urandom_range(1, 254)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        queue_random_beats(310, 6, 30);

        while (beats_accepted != beats_queued || responses_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && responses_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
